[sv/taacr_pkg.sv]
// ----------------------------------------------------------------------------
// taacr_pkg
// types, constants and the arctangent table shared by the angle-ratio check
// ----------------------------------------------------------------------------
package taacr_pkg;

  localparam int unsigned MaxSteps = 24;
  localparam int unsigned CoordW   = 32;
  localparam int unsigned DiffW    = 33;
  localparam int unsigned AngW     = 32;
  localparam int unsigned RatioW   = 24;
  localparam int unsigned CountW   = 4;
  localparam int unsigned DivW     = 33;
  localparam logic [CountW-1:0] SegHits = 4'd3;
  localparam logic signed [RatioW-1:0] RatioHi = 24'sh7FFFFF;
  localparam logic signed [RatioW-1:0] RatioLo = -24'sh800000;
  localparam logic [AngW-1:0] HalfTurn = 32'h8000_0000;
  localparam logic [AngW-1:0] RoundHalf = 32'h0000_8000;

  // register indexes on the configuration port
  localparam logic RegRatioMin = 1'b0;
  localparam logic RegRatioMax = 1'b1;

  // one vector on its way through the cordic
  typedef struct packed {
    logic signed [DiffW+1:0] x;
    logic signed [DiffW+1:0] y;
    logic [AngW-1:0]         z;
    logic                    zero;
  } vec_t;

  // classified item handed from the front to the back
  typedef struct packed {
    logic                    len_err;
    logic signed [15:0]      d1;
    logic signed [15:0]      d2;
  } cls_t;

  function automatic logic [AngW-1:0] atan_turn(input logic [4:0] i);
    logic [AngW-1:0] r;
    unique case (i)
      5'd0:  r = 32'h20000000;  5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;  5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;  5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;  5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;  5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;  5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;  5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;  5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;  5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;  5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;  5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;  5'd23: r = 32'h00000051;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

[sv/track_xy_angle_change_ratio_check_top.sv]
// ----------------------------------------------------------------------------
// track_xy_angle_change_ratio_check_top
// angle change ratio check of four track hits in the xy plane
// ----------------------------------------------------------------------------
// channel  | transfer when                    | payload
// command  | start_i && !busy_o               | hit counts, hit coordinates
// result   | done_o (one cycle)               | compatible, length error, ratio
// config   | psel & penable & pwrite & pready | ratio_min, ratio_max
//
// one item per cycle; the result transfer follows the command transfer through
// the input register, cordic pipeline (one micro-rotation per stage), front
// output register, queue slot and the 32-stage divider
// busy_o is always low; the receiver cannot stall and never needs to
// rst_ni clears the pipeline valids and loads the ratio limits
// ----------------------------------------------------------------------------
module track_xy_angle_change_ratio_check_top #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [taacr_pkg::CountW-1:0]     parent_hit_count_i,
  input  logic [taacr_pkg::CountW-1:0]     child_hit_count_i,
  input  logic signed [taacr_pkg::CoordW-1:0] hit_a_x_i,
  input  logic signed [taacr_pkg::CoordW-1:0] hit_a_y_i,
  input  logic signed [taacr_pkg::CoordW-1:0] hit_b_x_i,
  input  logic signed [taacr_pkg::CoordW-1:0] hit_b_y_i,
  input  logic signed [taacr_pkg::CoordW-1:0] hit_c_x_i,
  input  logic signed [taacr_pkg::CoordW-1:0] hit_c_y_i,
  input  logic signed [taacr_pkg::CoordW-1:0] hit_d_x_i,
  input  logic signed [taacr_pkg::CoordW-1:0] hit_d_y_i,
  output logic        done_o,
  output logic        compatible_o,
  output logic        length_error_o,
  output logic signed [taacr_pkg::RatioW-1:0] angle_ratio_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import taacr_pkg::*;

  logic signed [RatioW-1:0] ratio_min_q;
  logic signed [RatioW-1:0] ratio_max_q;
  logic wr_en;

  assign busy_o = 1'b0;
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // limit registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ratio_min_q <= RatioLo;
      ratio_max_q <= RatioHi;
    end else if (wr_en) begin
      if (paddr[2] == RegRatioMin) begin
        ratio_min_q <= pwdata[RatioW-1:0];
      end else begin
        ratio_max_q <= pwdata[RatioW-1:0];
      end
    end
  end

  // read back
  always_comb begin
    unique case (paddr)
      3'd0:    prdata = 32'(ratio_min_q);
      3'd4:    prdata = 32'(ratio_max_q);
      default: prdata = '0;
    endcase
  end

  logic fv, qv;
  cls_t fc, qc;

  taacr_front #(.CORDIC_STEPS(CORDIC_STEPS)) u_front (
    .clk_i, .rst_ni, .vld_i(start_i),
    .parent_hit_count_i, .child_hit_count_i,
    .hit_a_x_i, .hit_a_y_i, .hit_b_x_i, .hit_b_y_i,
    .hit_c_x_i, .hit_c_y_i, .hit_d_x_i, .hit_d_y_i,
    .vld_o(fv), .cls_o(fc)
  );

  taacr_queue u_queue (
    .clk_i, .rst_ni, .vld_i(fv), .cls_i(fc), .vld_o(qv), .cls_o(qc)
  );

  taacr_back u_back (
    .clk_i, .rst_ni, .vld_i(qv), .cls_i(qc),
    .ratio_min_i(ratio_min_q), .ratio_max_i(ratio_max_q),
    .valid_o(done_o), .compatible_o, .length_error_o, .angle_ratio_o
  );

endmodule

[sv/taacr_front.sv]
// ----------------------------------------------------------------------------
// taacr_front
// forms the three difference vectors, runs three pipelined cordics and
// classifies the item into two angle changes
// ----------------------------------------------------------------------------
module taacr_front #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             vld_i,
  input  logic [taacr_pkg::CountW-1:0]     parent_hit_count_i,
  input  logic [taacr_pkg::CountW-1:0]     child_hit_count_i,
  input  logic signed [taacr_pkg::CoordW-1:0] hit_a_x_i,
  input  logic signed [taacr_pkg::CoordW-1:0] hit_a_y_i,
  input  logic signed [taacr_pkg::CoordW-1:0] hit_b_x_i,
  input  logic signed [taacr_pkg::CoordW-1:0] hit_b_y_i,
  input  logic signed [taacr_pkg::CoordW-1:0] hit_c_x_i,
  input  logic signed [taacr_pkg::CoordW-1:0] hit_c_y_i,
  input  logic signed [taacr_pkg::CoordW-1:0] hit_d_x_i,
  input  logic signed [taacr_pkg::CoordW-1:0] hit_d_y_i,
  output logic                             vld_o,
  output taacr_pkg::cls_t                  cls_o
);
  import taacr_pkg::*;

  // input register stage: differences and length check
  logic               v0_q;
  logic               len_q;
  vec_t               in_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else begin
      v0_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    logic signed [DiffW-1:0] dx [3];
    logic signed [DiffW-1:0] dy [3];
    dx[0] = DiffW'(hit_b_x_i) - DiffW'(hit_a_x_i);
    dy[0] = DiffW'(hit_b_y_i) - DiffW'(hit_a_y_i);
    dx[1] = DiffW'(hit_c_x_i) - DiffW'(hit_b_x_i);
    dy[1] = DiffW'(hit_c_y_i) - DiffW'(hit_b_y_i);
    dx[2] = DiffW'(hit_d_x_i) - DiffW'(hit_c_x_i);
    dy[2] = DiffW'(hit_d_y_i) - DiffW'(hit_c_y_i);
    len_q <= (parent_hit_count_i != SegHits) || (child_hit_count_i != SegHits);
    for (int k = 0; k < 3; k++) begin
      in_q[k].zero <= (dx[k] == '0) && (dy[k] == '0);
      // left half plane is turned by a half turn
      if (dx[k] < 0) begin
        in_q[k].x <= -(DiffW+2)'(dx[k]);
        in_q[k].y <= -(DiffW+2)'(dy[k]);
        in_q[k].z <= HalfTurn;
      end else begin
        in_q[k].x <= (DiffW+2)'(dx[k]);
        in_q[k].y <= (DiffW+2)'(dy[k]);
        in_q[k].z <= '0;
      end
    end
  end

  // cordic pipeline, one micro-rotation per stage per vector
  vec_t pipe_q [CORDIC_STEPS+1][3];
  logic pv_q   [CORDIC_STEPS+1];
  logic pl_q   [CORDIC_STEPS+1];

  always_comb begin
    pipe_q[0] = in_q;
    pv_q[0]   = v0_q;
    pl_q[0]   = len_q;
  end

  for (genvar s = 0; s < CORDIC_STEPS; s++) begin : g_stage
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        pv_q[s+1] <= 1'b0;
      end else begin
        pv_q[s+1] <= pv_q[s];
      end
    end
    always_ff @(posedge clk_i) begin
      pl_q[s+1] <= pl_q[s];
      for (int k = 0; k < 3; k++) begin
        pipe_q[s+1][k].zero <= pipe_q[s][k].zero;
        if (!pipe_q[s][k].y[DiffW+1]) begin
          pipe_q[s+1][k].x <= pipe_q[s][k].x + (pipe_q[s][k].y >>> s);
          pipe_q[s+1][k].y <= pipe_q[s][k].y - (pipe_q[s][k].x >>> s);
          pipe_q[s+1][k].z <= pipe_q[s][k].z + atan_turn(5'(s));
        end else begin
          pipe_q[s+1][k].x <= pipe_q[s][k].x - (pipe_q[s][k].y >>> s);
          pipe_q[s+1][k].y <= pipe_q[s][k].y + (pipe_q[s][k].x >>> s);
          pipe_q[s+1][k].z <= pipe_q[s][k].z - atan_turn(5'(s));
        end
      end
    end
  end

  // azimuths and angle changes
  logic [15:0] az [3];
  always_comb begin
    logic [AngW-1:0] r;
    for (int k = 0; k < 3; k++) begin
      r = pipe_q[CORDIC_STEPS][k].z + RoundHalf;
      az[k] = pipe_q[CORDIC_STEPS][k].zero ? 16'd0 : r[AngW-1:16];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_o <= 1'b0;
    end else begin
      vld_o <= pv_q[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    cls_o.len_err <= pl_q[CORDIC_STEPS];
    cls_o.d1      <= signed'(az[0] - az[1]);
    cls_o.d2      <= signed'(az[1] - az[2]);
  end

endmodule

[sv/taacr_queue.sv]
// ----------------------------------------------------------------------------
// taacr_queue
// short register queue between the front and the back part
// ----------------------------------------------------------------------------
module taacr_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            vld_i,
  input  taacr_pkg::cls_t cls_i,
  output logic            vld_o,
  output taacr_pkg::cls_t cls_o
);
  import taacr_pkg::*;

  // the back never stalls, so one slot drains every cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_o <= 1'b0;
    end else begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld_i) begin
      cls_o <= cls_i;
    end
  end

endmodule

[sv/taacr_back.sv]
// ----------------------------------------------------------------------------
// taacr_back
// pipelined restoring divider for the angle change ratio, saturation and
// limit check
// ----------------------------------------------------------------------------
module taacr_back (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               vld_i,
  input  taacr_pkg::cls_t                    cls_i,
  input  logic signed [taacr_pkg::RatioW-1:0] ratio_min_i,
  input  logic signed [taacr_pkg::RatioW-1:0] ratio_max_i,
  output logic                               valid_o,
  output logic                               compatible_o,
  output logic                               length_error_o,
  output logic signed [taacr_pkg::RatioW-1:0] angle_ratio_o
);
  import taacr_pkg::*;

  // |d1|*65536 fits 32 bits, quotient up to 32 bits; one bit per stage
  localparam int unsigned QW = 32;

  typedef struct packed {
    logic              len_err;
    logic              neg;
    logic              nz1;
    logic              nz2;
    logic              pos1;
    logic [QW-1:0]     num;
    logic [16:0]       den;
    logic [16:0]       rem;
    logic [QW-1:0]     quo;
  } div_t;

  div_t dv_q [QW+1];
  logic dvv_q [QW+1];

  always_comb begin
    logic [16:0] a1;
    logic [16:0] a2;
    a1 = cls_i.d1[15] ? -17'(cls_i.d1) : 17'(cls_i.d1);
    a2 = cls_i.d2[15] ? -17'(cls_i.d2) : 17'(cls_i.d2);
    dvv_q[0]        = vld_i;
    dv_q[0].len_err = cls_i.len_err;
    dv_q[0].neg     = cls_i.d1[15] ^ cls_i.d2[15];
    dv_q[0].nz1     = cls_i.d1 != '0;
    dv_q[0].nz2     = cls_i.d2 != '0;
    dv_q[0].pos1    = !cls_i.d1[15];
    dv_q[0].num     = {a1[15:0], 16'h0000};
    dv_q[0].den     = a2;
    dv_q[0].rem     = '0;
    dv_q[0].quo     = '0;
  end

  // one quotient bit per stage
  for (genvar s = 0; s < QW; s++) begin : g_div
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dvv_q[s+1] <= 1'b0;
      end else begin
        dvv_q[s+1] <= dvv_q[s];
      end
    end
    always_ff @(posedge clk_i) begin
      logic [17:0] t;
      div_t        n;
      n = dv_q[s];
      t = {dv_q[s].rem, dv_q[s].num[QW-1-s]};
      if (t >= {1'b0, dv_q[s].den}) begin
        n.rem = 17'(t - {1'b0, dv_q[s].den});
        n.quo = {dv_q[s].quo[QW-2:0], 1'b1};
      end else begin
        n.rem = t[16:0];
        n.quo = {dv_q[s].quo[QW-2:0], 1'b0};
      end
      dv_q[s+1] <= n;
    end
  end

  // sign, saturation and limits
  always_comb begin
    div_t f;
    logic signed [RatioW-1:0] r;
    f = dv_q[QW];
    if (!f.nz2) begin
      r = f.pos1 ? RatioHi : RatioLo;
    end else if (f.neg) begin
      r = (f.quo > 32'd8388608) ? RatioLo : RatioW'(-f.quo);
    end else begin
      r = (f.quo > 32'd8388607) ? RatioHi : RatioW'(f.quo);
    end
    valid_o = dvv_q[QW];
    if (f.len_err) begin
      compatible_o   = 1'b0;
      length_error_o = 1'b1;
      angle_ratio_o  = '0;
    end else if (!f.nz1 && !f.nz2) begin
      compatible_o   = 1'b1;
      length_error_o = 1'b0;
      angle_ratio_o  = '0;
    end else begin
      compatible_o   = (r >= ratio_min_i) && (r <= ratio_max_i);
      length_error_o = 1'b0;
      angle_ratio_o  = r;
    end
  end

  // a length error never claims compatibility
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && length_error_o |-> !compatible_o)
    else $error("length error with compatible set");

  // a zero-divisor ratio with a nonzero numerator is saturated to one of the limits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !length_error_o && !dv_q[QW].nz2 && dv_q[QW].nz1 |->
      (angle_ratio_o == RatioHi || angle_ratio_o == RatioLo))
    else $error("zero divisor not saturated");

  // the last divider stage never fires without its predecessor having fired
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dvv_q[QW] |-> $past(dvv_q[QW-1]))
    else $error("divider valid out of sequence");

endmodule
